@@ design/ecsm_pkg.sv @@
// Shared types, constants and modular helpers for the elliptic-curve scalar multiplier.
// Used by ecsm_ctrl, ecsm_dp and ec_scalar_multiply_mod; no dependencies.
`default_nettype none
package ecsm_pkg;
  localparam int WIDTH = 32;
  localparam int CW = $clog2(WIDTH);
  localparam int CFG_IDX_W = 1;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ST_FINITE   = 2'd0,
    ST_INFINITY = 2'd1,
    ST_FAIL     = 2'd2
  } res_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_A = 1'b0,
    REG_MODULUS = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_LOAD, OP_RED_X, OP_RED_Y, OP_RED_A, OP_COPY, OP_SET_INF,
    OP_TAN_MUL, OP_TAN_N1, OP_TAN_N2, OP_TAN_N3, OP_CHORD,
    OP_EG_INIT, OP_EG_DIV, OP_EG_MUL, OP_EG_STEP,
    OP_LAM, OP_X3A, OP_X3B, OP_Y3A, OP_Y3B, OP_Y3C, OP_SHIFT, OP_FAIL
  } dp_op_t;

  typedef struct packed {
    logic   go;
    logic   dbl;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic k_zero;
    logic k_lsb;
    logic p_inf;
    logic q_inf;
    logic x_eq;
    logic ysum_zero;
    logic r1_zero;
    logic r0_one;
  } dp_stat_t;

  function automatic word_t madd(input word_t a, input word_t b, input word_t m);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  function automatic word_t msub(input word_t a, input word_t b, input word_t m);
    word_t d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + (m - b);
    end
    return d;
  endfunction
endpackage
`default_nettype wire

@@ design/ec_scalar_multiply_mod.sv @@
// Top level of the elliptic-curve scalar multiplier: configuration registers,
// controller and datapath. Depends on ecsm_pkg, ecsm_ctrl and ecsm_dp.
//
// One input beat is taken when start is high and busy is low; the result beat
// appears for exactly one cycle with out_valid and cannot be stalled. Work is
// sequential: a multiply, a reduction or a division runs on one shared bit-serial
// unit, and a short step updates the registers directly. An addition or a doubling
// that needs an inverse runs one Euclid step per quotient. Each scalar bit costs
// one addition when it is set and one doubling while higher bits remain. The
// number of scalar bits and of Euclid steps sets the total run time.
`default_nettype none
module ec_scalar_multiply_mod (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [ecsm_pkg::WIDTH-1:0]        in_scalar,
  input  wire [ecsm_pkg::WIDTH-1:0]        in_point_x,
  input  wire [ecsm_pkg::WIDTH-1:0]        in_point_y,
  input  wire                              in_point_at_infinity,
  output logic                             out_valid,
  output logic [ecsm_pkg::WIDTH-1:0]       out_result_x,
  output logic [ecsm_pkg::WIDTH-1:0]       out_result_y,
  output logic [1:0]                       out_status,
  output logic [ecsm_pkg::WIDTH-1:0]       out_factor,
  input  wire                              cfg_we,
  input  wire [ecsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ecsm_pkg::WIDTH-1:0]        cfg_wdata
);
  import ecsm_pkg::*;

  word_t    curve_a_r, modulus_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r <= '0;
      modulus_r <= word_t'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CURVE_A: curve_a_r <= cfg_wdata;
        REG_MODULUS: modulus_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ecsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  ecsm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_scalar            (in_scalar),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_point_at_infinity (in_point_at_infinity),
    .cfg_a                (curve_a_r),
    .cfg_m                (modulus_r),
    .res_x                (out_result_x),
    .res_y                (out_result_y),
    .res_status           (out_status),
    .res_factor           (out_factor)
  );
endmodule
`default_nettype wire

@@ design/ecsm_dp.sv @@
// Datapath: point registers, Euclid registers and one shared bit-serial unit that
// does modular multiply or restoring division. Depends on ecsm_pkg.
`default_nettype none
module ecsm_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ecsm_pkg::dp_cmd_t      cmd,
  output ecsm_pkg::dp_stat_t     stat,
  input  wire [ecsm_pkg::WIDTH-1:0] in_scalar,
  input  wire [ecsm_pkg::WIDTH-1:0] in_point_x,
  input  wire [ecsm_pkg::WIDTH-1:0] in_point_y,
  input  wire                    in_point_at_infinity,
  input  wire [ecsm_pkg::WIDTH-1:0] cfg_a,
  input  wire [ecsm_pkg::WIDTH-1:0] cfg_m,
  output logic [ecsm_pkg::WIDTH-1:0] res_x,
  output logic [ecsm_pkg::WIDTH-1:0] res_y,
  output logic [1:0]             res_status,
  output logic [ecsm_pkg::WIDTH-1:0] res_factor
);
  import ecsm_pkg::*;

  word_t m_r, a_r, k_r, px_r, py_r, rx_r, ry_r, n_r, d_r, tmp_r, x3_r;
  word_t r0_r, r1_r, t0_r, t1_r, q_r, r2_r, fail_r;
  logic  pinf_r, rinf_r, failed_r;
  logic  run_r, done_r, divmode_r;
  logic [CW-1:0] cnt_r;
  dp_op_t op_r;
  word_t u_a_r, u_b_r, u_acc_r, u_rem_r;

  word_t qx, qy;
  logic  qinf;
  logic [WIDTH:0] remsh;
  logic  qbit;
  word_t rem_nxt, acc_nxt, a_nxt;

  assign qx   = cmd.dbl ? px_r : rx_r;
  assign qy   = cmd.dbl ? py_r : ry_r;
  assign qinf = cmd.dbl ? pinf_r : rinf_r;

  assign stat.done      = done_r;
  assign stat.k_zero    = (k_r == '0);
  assign stat.k_lsb     = k_r[0];
  assign stat.p_inf     = pinf_r;
  assign stat.q_inf     = qinf;
  assign stat.x_eq      = (px_r == qx);
  assign stat.ysum_zero = (madd(py_r, qy, m_r) == '0);
  assign stat.r1_zero   = (r1_r == '0);
  assign stat.r0_one    = (r0_r == word_t'(1));

  always_comb begin
    remsh   = {u_rem_r, u_a_r[WIDTH-1]};
    qbit    = (remsh >= {1'b0, u_b_r});
    rem_nxt = qbit ? word_t'(remsh - {1'b0, u_b_r}) : remsh[WIDTH-1:0];
    if (divmode_r) begin
      acc_nxt = {u_acc_r[WIDTH-2:0], qbit};
      a_nxt   = {u_a_r[WIDTH-2:0], 1'b0};
    end else begin
      acc_nxt = u_b_r[0] ? madd(u_acc_r, u_a_r, m_r) : u_acc_r;
      a_nxt   = madd(u_a_r, u_a_r, m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (run_r) begin
        u_a_r   <= a_nxt;
        u_acc_r <= acc_nxt;
        u_rem_r <= rem_nxt;
        if (!divmode_r) begin
          u_b_r <= u_b_r >> 1;
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          unique case (op_r)
            OP_RED_X: px_r <= rem_nxt;
            OP_RED_Y: py_r <= rem_nxt;
            OP_RED_A: a_r  <= rem_nxt;
            OP_TAN_MUL: n_r <= acc_nxt;
            OP_EG_DIV: begin
              q_r  <= (acc_nxt >= m_r) ? acc_nxt - m_r : acc_nxt;
              r2_r <= rem_nxt;
            end
            OP_EG_MUL: tmp_r <= acc_nxt;
            OP_LAM:    n_r   <= acc_nxt;
            OP_X3A:    tmp_r <= acc_nxt;
            OP_Y3B:    tmp_r <= acc_nxt;
            default: ;
          endcase
        end
      end else if (cmd.go) begin
        op_r    <= cmd.op;
        u_acc_r <= '0;
        u_rem_r <= '0;
        cnt_r   <= CW'(WIDTH - 1);
        unique case (cmd.op)
          OP_RED_X, OP_RED_Y, OP_RED_A, OP_EG_DIV: begin
            run_r     <= 1'b1;
            divmode_r <= 1'b1;
            unique case (cmd.op)
              OP_RED_X: u_a_r <= px_r;
              OP_RED_Y: u_a_r <= py_r;
              OP_RED_A: u_a_r <= a_r;
              default:  u_a_r <= r0_r;
            endcase
            u_b_r <= (cmd.op == OP_EG_DIV) ? r1_r : m_r;
          end
          OP_TAN_MUL, OP_EG_MUL, OP_LAM, OP_X3A, OP_Y3B: begin
            run_r     <= 1'b1;
            divmode_r <= 1'b0;
            unique case (cmd.op)
              OP_TAN_MUL: begin u_a_r <= px_r; u_b_r <= px_r; end
              OP_EG_MUL:  begin u_a_r <= q_r;  u_b_r <= t1_r; end
              OP_LAM:     begin u_a_r <= n_r;  u_b_r <= t0_r; end
              OP_X3A:     begin u_a_r <= n_r;  u_b_r <= n_r;  end
              default:    begin u_a_r <= n_r;  u_b_r <= tmp_r; end
            endcase
          end
          default: begin
            done_r <= 1'b1;
            unique case (cmd.op)
              OP_LOAD: begin
                m_r      <= (cfg_m < word_t'(2)) ? word_t'(2) : cfg_m;
                a_r      <= cfg_a;
                k_r      <= in_scalar;
                px_r     <= in_point_x;
                py_r     <= in_point_y;
                pinf_r   <= in_point_at_infinity;
                rx_r     <= '0;
                ry_r     <= '0;
                rinf_r   <= 1'b1;
                failed_r <= 1'b0;
                fail_r   <= '0;
              end
              OP_COPY: begin
                rx_r   <= px_r;
                ry_r   <= py_r;
                rinf_r <= pinf_r;
              end
              OP_SET_INF: begin
                if (cmd.dbl) begin
                  px_r <= '0; py_r <= '0; pinf_r <= 1'b1;
                end else begin
                  rx_r <= '0; ry_r <= '0; rinf_r <= 1'b1;
                end
              end
              OP_TAN_N1: tmp_r <= madd(n_r, n_r, m_r);
              OP_TAN_N2: n_r   <= madd(tmp_r, n_r, m_r);
              OP_TAN_N3: begin
                n_r <= madd(n_r, a_r, m_r);
                d_r <= madd(py_r, py_r, m_r);
              end
              OP_CHORD: begin
                n_r <= msub(qy, py_r, m_r);
                d_r <= msub(qx, px_r, m_r);
              end
              OP_EG_INIT: begin
                r0_r <= m_r;
                r1_r <= d_r;
                t0_r <= '0;
                t1_r <= word_t'(1);
              end
              OP_EG_STEP: begin
                r0_r <= r1_r;
                r1_r <= r2_r;
                t0_r <= t1_r;
                t1_r <= msub(t0_r, tmp_r, m_r);
              end
              OP_X3B: x3_r  <= msub(msub(tmp_r, px_r, m_r), qx, m_r);
              OP_Y3A: tmp_r <= msub(px_r, x3_r, m_r);
              OP_Y3C: begin
                if (cmd.dbl) begin
                  px_r <= x3_r; py_r <= msub(tmp_r, py_r, m_r); pinf_r <= 1'b0;
                end else begin
                  rx_r <= x3_r; ry_r <= msub(tmp_r, py_r, m_r); rinf_r <= 1'b0;
                end
              end
              OP_SHIFT: k_r <= k_r >> 1;
              OP_FAIL: begin
                failed_r <= 1'b1;
                fail_r   <= r0_r;
              end
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  always_comb begin
    if (failed_r) begin
      res_x = '0; res_y = '0; res_status = ST_FAIL; res_factor = fail_r;
    end else if (rinf_r) begin
      res_x = '0; res_y = '0; res_status = ST_INFINITY; res_factor = '0;
    end else begin
      res_x = rx_r; res_y = ry_r; res_status = ST_FINITE; res_factor = '0;
    end
  end

  a_no_go_while_running: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |-> !run_r) else $error("command issued while unit running");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && cnt_r == '0) |=> (done_r && !run_r)) else $error("unit did not finish");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("done while running");
endmodule
`default_nettype wire

@@ design/ecsm_ctrl.sv @@
// Controller: sequences double-and-add, point operations and Euclid steps
// as commands to ecsm_dp. Depends on ecsm_pkg.
`default_nettype none
module ecsm_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  output logic               out_valid,
  output ecsm_pkg::dp_cmd_t  cmd,
  input  ecsm_pkg::dp_stat_t stat
);
  import ecsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RED_X, S_RED_Y, S_RED_A, S_LOOP, S_ADD, S_AFTER,
    S_COPY, S_SETINF, S_TMUL, S_TN1, S_TN2, S_TN3, S_CHORD, S_EGI, S_EGCHK,
    S_EGDIV, S_EGMUL, S_EGSTEP, S_LAM, S_X3A, S_X3B, S_Y3A, S_Y3B, S_Y3C,
    S_SHIFT, S_FAIL, S_DONE
  } state_t;

  state_t state_r;
  logic   issued_r, dbl_r;
  logic   is_op;
  dp_op_t op;

  always_comb begin
    is_op = 1'b1;
    unique case (state_r)
      S_LOAD:   op = OP_LOAD;
      S_RED_X:  op = OP_RED_X;
      S_RED_Y:  op = OP_RED_Y;
      S_RED_A:  op = OP_RED_A;
      S_COPY:   op = OP_COPY;
      S_SETINF: op = OP_SET_INF;
      S_TMUL:   op = OP_TAN_MUL;
      S_TN1:    op = OP_TAN_N1;
      S_TN2:    op = OP_TAN_N2;
      S_TN3:    op = OP_TAN_N3;
      S_CHORD:  op = OP_CHORD;
      S_EGI:    op = OP_EG_INIT;
      S_EGDIV:  op = OP_EG_DIV;
      S_EGMUL:  op = OP_EG_MUL;
      S_EGSTEP: op = OP_EG_STEP;
      S_LAM:    op = OP_LAM;
      S_X3A:    op = OP_X3A;
      S_X3B:    op = OP_X3B;
      S_Y3A:    op = OP_Y3A;
      S_Y3B:    op = OP_Y3B;
      S_Y3C:    op = OP_Y3C;
      S_SHIFT:  op = OP_SHIFT;
      S_FAIL:   op = OP_FAIL;
      default: begin
        op    = OP_LOAD;
        is_op = 1'b0;
      end
    endcase
  end

  assign cmd.op  = op;
  assign cmd.dbl = dbl_r;
  assign cmd.go  = (state_r == S_IDLE) ? start : (is_op && !issued_r);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      dbl_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r  <= S_LOAD;
            issued_r <= 1'b1;
          end
        end
        S_LOOP: begin
          if (stat.k_zero) begin
            state_r <= S_DONE;
          end else if (stat.k_lsb) begin
            dbl_r   <= 1'b0;
            state_r <= S_ADD;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_ADD: begin
          priority if (stat.p_inf) begin
            state_r <= S_AFTER;
          end else if (stat.q_inf) begin
            state_r <= S_COPY;
          end else if (stat.x_eq && stat.ysum_zero) begin
            state_r <= S_SETINF;
          end else if (stat.x_eq) begin
            state_r <= S_TMUL;
          end else begin
            state_r <= S_CHORD;
          end
        end
        S_AFTER: state_r <= dbl_r ? S_LOOP : S_SHIFT;
        S_EGCHK: begin
          if (!stat.r1_zero) begin
            state_r <= S_EGDIV;
          end else begin
            state_r <= stat.r0_one ? S_LAM : S_FAIL;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (stat.done) begin
            issued_r <= 1'b0;
            unique case (state_r)
              S_LOAD:   state_r <= S_RED_X;
              S_RED_X:  state_r <= S_RED_Y;
              S_RED_Y:  state_r <= S_RED_A;
              S_RED_A:  state_r <= S_LOOP;
              S_TMUL:   state_r <= S_TN1;
              S_TN1:    state_r <= S_TN2;
              S_TN2:    state_r <= S_TN3;
              S_TN3:    state_r <= S_EGI;
              S_CHORD:  state_r <= S_EGI;
              S_EGI:    state_r <= S_EGCHK;
              S_EGDIV:  state_r <= S_EGMUL;
              S_EGMUL:  state_r <= S_EGSTEP;
              S_EGSTEP: state_r <= S_EGCHK;
              S_LAM:    state_r <= S_X3A;
              S_X3A:    state_r <= S_X3B;
              S_X3B:    state_r <= S_Y3A;
              S_Y3A:    state_r <= S_Y3B;
              S_Y3B:    state_r <= S_Y3C;
              S_SHIFT: begin
                if (stat.k_zero) begin
                  state_r <= S_DONE;
                end else begin
                  dbl_r   <= 1'b1;
                  state_r <= S_ADD;
                end
              end
              S_FAIL:   state_r <= S_DONE;
              default:  state_r <= S_AFTER;
            endcase
          end
        end
      endcase
    end
  end

  a_valid_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not start work");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("controller did not return to idle");
endmodule
`default_nettype wire
